@@ hdl/ordered_list_table_core_macros.svh @@
// ----------------------------------------------------------------------------
// ordered list table assertion macros
// property shorthands for the ordered list table; empty under synthesis
// ----------------------------------------------------------------------------
`ifndef ORDERED_LIST_TABLE_CORE_MACROS_SVH
`define ORDERED_LIST_TABLE_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define OLT_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ordered list table: check failed");
`define OLT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ordered list table: check failed");
`else
`define OLT_ASSERT_IMPL(label, ante, cons)
`define OLT_ASSERT_NEXT(label, ante, cons)
`endif

`endif

@@ hdl/olt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// olt_pkg
// shared types and constants of the ordered list table
// ----------------------------------------------------------------------------
package olt_pkg;

    localparam int OP_W        = 3;
    localparam int VAL_W       = 32;
    localparam int POS_W       = 7;
    localparam int CNT_OUT_W   = 7;
    localparam int ST_W        = 2;
    // index width for the largest supported list (up to 1024 entries)
    localparam int CNT_MAX_W   = 11;
    localparam int CAP_DEFAULT = 64;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND   = 3'd0,
        OP_READ     = 3'd1,
        OP_DELETE   = 3'd2,
        OP_COUNT    = 3'd3,
        OP_CLEAR    = 3'd4,
        OP_CONTAINS = 3'd5
    } t_olt_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_olt_status;

    typedef struct packed {
        logic [OP_W-1:0]         opcode;
        logic signed [VAL_W-1:0] value_in;
        logic [POS_W-1:0]        position;
    } t_olt_in;

    typedef struct packed {
        logic signed [VAL_W-1:0] value_out;
        logic                    found;
        logic [CNT_OUT_W-1:0]    entry_count;
        logic [ST_W-1:0]         status;
    } t_olt_out;

    // broadcast from the controller to every cell of the chain
    typedef struct packed {
        logic                 load;
        logic                 app_en;
        logic                 shift_en;
        logic                 rd_en;
        logic                 srch_en;
        logic [CNT_MAX_W-1:0] tail;
        logic [CNT_MAX_W-1:0] slot;
        logic [CNT_MAX_W-1:0] last;
        logic [VAL_W-1:0]     value;
    } t_olt_cmd;

endpackage
`default_nettype wire

@@ hdl/olt_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// olt_cell
// one list slot: holds an entry, takes its right neighbor's entry on delete,
// and registers its share of the read and search results
// ----------------------------------------------------------------------------
module olt_cell
    import olt_pkg::*;
#(
    parameter int CELL_IDX = 0
) (
    input  wire logic                 i_clk,
    input  wire t_olt_cmd             i_cmd,
    input  wire logic [VAL_W-1:0]     i_next_entry,
    output logic      [VAL_W-1:0]     o_entry,
    output logic      [VAL_W-1:0]     o_rd_data,
    output logic                      o_hit
);

    localparam logic [CNT_MAX_W-1:0] ThisIdx = CNT_MAX_W'(CELL_IDX);

    logic [VAL_W-1:0] r_entry;
    logic [VAL_W-1:0] n_entry;
    logic [VAL_W-1:0] r_rd_data;
    logic             r_hit;
    logic             wr_app;
    logic             wr_shift;
    logic             rd_sel;
    logic             srch_hit;

    always_comb begin
        wr_app   = i_cmd.app_en && (ThisIdx == i_cmd.tail);
        // delete closes the gap: cells from the removed slot up to, but not including, the last entry pull left
        wr_shift = i_cmd.shift_en && (ThisIdx >= i_cmd.slot) && (ThisIdx < i_cmd.last);
        rd_sel   = i_cmd.rd_en && (ThisIdx == i_cmd.slot);
        srch_hit = i_cmd.srch_en && (ThisIdx < i_cmd.tail) && (r_entry == i_cmd.value);
        priority if (wr_app) begin
            n_entry = i_cmd.value;
        end else if (wr_shift) begin
            n_entry = i_next_entry;
        end else begin
            n_entry = r_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        if (i_cmd.load) begin
            r_rd_data <= rd_sel ? r_entry : '0;
            r_hit     <= srch_hit;
        end
    end

    assign o_entry   = r_entry;
    assign o_rd_data = r_rd_data;
    assign o_hit     = r_hit;

endmodule
`default_nettype wire

@@ hdl/ordered_list_table_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ordered_list_table_core
// ordered list of signed 32-bit values held in a chain of cells
// ----------------------------------------------------------------------------
// usage:
//   input channel  i_in_valid / o_in_stall / i_in_data  (opcode, value, position)
//   output channel o_out_valid / i_out_stall / o_out_data (value, found, count,
//   status). every request gives exactly one result, in order.
//   append, read, delete, count, clear and contains all act on every cell at
//   once in the cycle the request is taken; delete shifts the tail one cell left.
//   from request to result, the cells are first updated and each cell's read
//   and match bits registered; the output register then ors them together.
//   throughput is one request per cycle while the output is not stalled.
//   when i_out_stall holds a result, one more request can be taken into the
//   middle stage; after that o_in_stall rises until the output drains.
//   reset empties the list (count zero) and drops any request in flight; the
//   entry storage itself is not cleared and needs no pass after reset.
// ----------------------------------------------------------------------------
`include "ordered_list_table_core_macros.svh"

module ordered_list_table_core
    import olt_pkg::*;
#(
    parameter int CAPACITY = CAP_DEFAULT
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_stall,
    input  wire t_olt_in  i_in_data,
    output logic          o_out_valid,
    input  wire logic     i_out_stall,
    output t_olt_out      o_out_data
);

    localparam int CntW = $clog2(CAPACITY + 1);

    logic [CntW-1:0]      r_count;
    logic [CntW-1:0]      n_count;
    logic                 r_s1_valid;
    logic [CNT_OUT_W-1:0] r_s1_cnt;
    logic [ST_W-1:0]      r_s1_status;
    logic                 r_out_valid;
    t_olt_out             r_out;

    logic                 acc;
    logic                 adv_out;
    logic                 full;
    logic                 pos_ok;
    logic [CNT_MAX_W-1:0] cnt_x;
    logic [CNT_MAX_W-1:0] pos_x;
    logic [CNT_MAX_W-1:0] n_cnt_x;
    logic [ST_W-1:0]      n_status;
    t_olt_cmd             cmd;

    logic [VAL_W-1:0]     cell_entry [CAPACITY];
    logic [VAL_W-1:0]     cell_rd    [CAPACITY];
    logic                 cell_hit   [CAPACITY];
    logic [VAL_W-1:0]     rd_or;
    logic                 hit_or;

    assign adv_out    = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_s1_valid && !adv_out;
    assign acc        = i_in_valid && !o_in_stall;

    assign cnt_x  = CNT_MAX_W'(r_count);
    assign pos_x  = CNT_MAX_W'(i_in_data.position);
    assign pos_ok = (pos_x != '0) && (pos_x <= cnt_x);
    assign full   = (r_count == CntW'(CAPACITY));

    always_comb begin
        n_count      = r_count;
        n_status     = ST_OK;
        cmd          = '0;
        cmd.tail     = cnt_x;
        cmd.slot     = pos_x - 1'b1;
        cmd.last     = cnt_x - 1'b1;
        cmd.value    = i_in_data.value_in;
        unique case (i_in_data.opcode)
            OP_APPEND: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    cmd.app_en = 1'b1;
                    n_count    = CntW'(r_count + 1'b1);
                end
            end
            OP_READ: begin
                if (pos_ok) begin
                    cmd.rd_en = 1'b1;
                end else begin
                    n_status = ST_RANGE;
                end
            end
            OP_DELETE: begin
                if (pos_ok) begin
                    cmd.shift_en = 1'b1;
                    n_count      = CntW'(r_count - 1'b1);
                end else begin
                    n_status = ST_RANGE;
                end
            end
            OP_CLEAR: begin
                n_count = '0;
            end
            OP_CONTAINS: begin
                cmd.srch_en = 1'b1;
            end
            default: begin
                // count and unused codes leave everything as it is
            end
        endcase
        cmd.load     = acc;
        cmd.app_en   = cmd.app_en && acc;
        cmd.shift_en = cmd.shift_en && acc;
        cmd.rd_en    = cmd.rd_en && acc;
        cmd.srch_en  = cmd.srch_en && acc;
    end

    assign n_cnt_x = CNT_MAX_W'(n_count);

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [VAL_W-1:0] next_entry;
        if (g == CAPACITY - 1) begin : g_end
            assign next_entry = cell_entry[g];
        end else begin : g_mid
            assign next_entry = cell_entry[g+1];
        end

        olt_cell #(
            .CELL_IDX (g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_cmd        (cmd),
            .i_next_entry (next_entry),
            .o_entry      (cell_entry[g]),
            .o_rd_data    (cell_rd[g]),
            .o_hit        (cell_hit[g])
        );
    end

    // at most one cell drives a nonzero read word
    always_comb begin
        rd_or  = '0;
        hit_or = 1'b0;
        for (int k = 0; k < CAPACITY; k++) begin
            rd_or  = rd_or | cell_rd[k];
            hit_or = hit_or | cell_hit[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (acc) begin
                r_count <= n_count;
            end
            if (acc) begin
                r_s1_valid <= 1'b1;
            end else if (adv_out) begin
                r_s1_valid <= 1'b0;
            end
            if (adv_out) begin
                r_out_valid <= r_s1_valid;
            end
        end
        if (acc) begin
            r_s1_cnt    <= n_cnt_x[CNT_OUT_W-1:0];
            r_s1_status <= n_status;
        end
        if (adv_out && r_s1_valid) begin
            r_out.value_out   <= rd_or;
            r_out.found       <= hit_or;
            r_out.entry_count <= r_s1_cnt;
            r_out.status      <= r_s1_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `OLT_ASSERT_IMPL(a_cnt_cap, 1'b1, r_count <= CntW'(CAPACITY))
    `OLT_ASSERT_NEXT(a_app_inc, cmd.app_en, r_count == CntW'($past(r_count) + 1'b1))
    `OLT_ASSERT_IMPL(a_found_ok, r_out_valid && r_out.found, r_out.status == ST_OK)
    `OLT_ASSERT_IMPL(a_stall_src, o_in_stall, r_s1_valid && r_out_valid)

endmodule
`default_nettype wire

@@ verif/ordered_list_table_core_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_table_core_test
// self-checking bench for the ordered list table: a directed opening, then
// about 1300 random requests in fill, mixed and drain mixes under four
// flow-control patterns, each result checked against a software list
// ----------------------------------------------------------------------------
import olt_pkg::*;

class list_tracker;
    localparam int LIST_CAP = CAP_DEFAULT;

    logic signed [VAL_W-1:0] entries [LIST_CAP];
    int unsigned             level;
    t_olt_out                pending_results[$];
    int                      errors;
    int                      checked;
    int                      requests;
    int                      full_refusals;
    int                      range_errors;
    int                      hits;

    function new();
        level = 0;
        errors = 0;
        checked = 0;
        requests = 0;
        full_refusals = 0;
        range_errors = 0;
        hits = 0;
    endfunction

    // applies one request to the software list and returns its result
    function t_olt_out apply_request(t_olt_in req);
        t_olt_out res;
        int unsigned p;
        bit pos_ok;
        res = '0;
        res.status = ST_OK;
        p = 32'(req.position);
        pos_ok = (p >= 1) && (p <= level);
        case (req.opcode)
            OP_APPEND: begin
                if (level >= LIST_CAP) begin
                    res.status = ST_FULL;
                end else begin
                    entries[level] = req.value_in;
                    level++;
                end
            end
            OP_READ: begin
                if (pos_ok) res.value_out = entries[p-1];
                else res.status = ST_RANGE;
            end
            OP_DELETE: begin
                if (pos_ok) begin
                    for (int i = p - 1; i + 1 < level; i++) entries[i] = entries[i+1];
                    level--;
                end else begin
                    res.status = ST_RANGE;
                end
            end
            OP_CLEAR: level = 0;
            OP_CONTAINS: begin
                for (int i = 0; i < level; i++) begin
                    if (entries[i] == req.value_in) res.found = 1'b1;
                end
            end
            default: ;
        endcase
        res.entry_count = level[CNT_OUT_W-1:0];
        return res;
    endfunction

    function void note_request(t_olt_in req);
        t_olt_out res;
        res = apply_request(req);
        requests++;
        if (res.status == ST_FULL) full_refusals++;
        if (res.status == ST_RANGE) range_errors++;
        if (res.found) hits++;
        pending_results.push_back(res);
    endfunction

    function void check_result(t_olt_out got);
        t_olt_out want;
        if (pending_results.size() == 0) begin
            $error("result with no request outstanding: %h", got);
            errors++;
            return;
        end
        want = pending_results.pop_front();
        checked++;
        if (got.value_out !== want.value_out) begin
            $error("value_out mismatch: expected %0d, got %0d", want.value_out, got.value_out);
            errors++;
        end
        if (got.found !== want.found) begin
            $error("found mismatch: expected %0d, got %0d", want.found, got.found);
            errors++;
        end
        if (got.entry_count !== want.entry_count) begin
            $error("entry_count mismatch: expected %0d, got %0d",
                   want.entry_count, got.entry_count);
            errors++;
        end
        if (got.status !== want.status) begin
            $error("status mismatch: expected %0d, got %0d", want.status, got.status);
            errors++;
        end
    endfunction

    function int pending();
        return pending_results.size();
    endfunction
endclass

module ordered_list_table_core_test;

    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 12;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 160;
    localparam int TIMEOUT_NS    = 2_000_000;

    // opcodes the block does not define; they must act as no-ops
    localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

    localparam int MIX_FILL  = 0;
    localparam int MIX_BLEND = 1;
    localparam int MIX_DRAIN = 2;

    logic     i_clk       = 1'b0;
    logic     i_rst_n     = 1'b0;
    logic     i_in_valid  = 1'b0;
    t_olt_in  i_in_data   = '0;
    logic     i_out_stall = 1'b0;
    logic     o_in_stall;
    logic     o_out_valid;
    t_olt_out o_out_data;

    int          src_idle_pct  = 0;
    int          sink_stall_pct = 0;
    list_tracker sb;

    ordered_list_table_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // result side: check what is taken, then pick the next stall
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_result(o_out_data);
        i_out_stall <= (sink_stall_pct > 0) && ($urandom_range(99) < sink_stall_pct);
    end

    task automatic send_request(input logic [OP_W-1:0] op, input logic [VAL_W-1:0] val,
                                input logic [POS_W-1:0] pos);
        t_olt_in req;
        req.opcode   = op;
        req.value_in = val;
        req.position = pos;
        while (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_request(req);
    endtask

    function automatic logic [VAL_W-1:0] pick_value();
        int r;
        r = $urandom_range(9);
        case (r)
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return '0;
            3: return '1;
            4, 5, 6: return int'($urandom_range(15)) - 8;
            default: return $urandom;
        endcase
    endfunction

    // while the list is not empty, half of the contains probes look for something that is held
    function automatic logic [VAL_W-1:0] pick_probe();
        if (sb.level > 0 && $urandom_range(1)) return sb.entries[$urandom_range(sb.level - 1)];
        return pick_value();
    endfunction

    function automatic logic [POS_W-1:0] pick_position();
        int r;
        int n;
        r = $urandom_range(9);
        n = sb.level;
        case (r)
            0: return '0;
            1: return (n + 1 > 127) ? 7'd127 : POS_W'(n + 1);
            2: return POS_W'($urandom_range(127));
            default: return (n > 0) ? POS_W'($urandom_range(n, 1)) : '0;
        endcase
    endfunction

    function automatic logic [OP_W-1:0] pick_op(input int mix);
        int r;
        r = $urandom_range(99);
        case (mix)
            MIX_FILL: begin
                if (r < 70) return OP_APPEND;
                if (r < 78) return OP_READ;
                if (r < 86) return OP_CONTAINS;
                if (r < 90) return OP_DELETE;
                if (r < 95) return OP_COUNT;
                if (r < 96) return OP_CLEAR;
                if (r < 98) return OP_SPARE_LO;
                return OP_SPARE_HI;
            end
            MIX_DRAIN: begin
                if (r < 15) return OP_APPEND;
                if (r < 30) return OP_READ;
                if (r < 75) return OP_DELETE;
                if (r < 90) return OP_CONTAINS;
                if (r < 95) return OP_COUNT;
                if (r < 97) return OP_CLEAR;
                if (r < 99) return OP_SPARE_LO;
                return OP_SPARE_HI;
            end
            default: begin
                if (r < 30) return OP_APPEND;
                if (r < 50) return OP_READ;
                if (r < 65) return OP_DELETE;
                if (r < 85) return OP_CONTAINS;
                if (r < 92) return OP_COUNT;
                if (r < 95) return OP_CLEAR;
                if (r < 97) return OP_SPARE_LO;
                return OP_SPARE_HI;
            end
        endcase
    endfunction

    initial begin
        logic [OP_W-1:0] op;
        logic [VAL_W-1:0] val;
        sb = new();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty list, edge values, every position boundary, spare opcodes
        send_request(OP_COUNT,    '0, '0);
        send_request(OP_READ,     '0, 7'd1);
        send_request(OP_DELETE,   '0, 7'd1);
        send_request(OP_CONTAINS, '0, '0);
        send_request(OP_APPEND,   32'h8000_0000, '0);
        send_request(OP_APPEND,   32'h7fff_ffff, 7'd127);
        send_request(OP_APPEND,   '0, '0);
        send_request(OP_APPEND,   '1, '0);
        send_request(OP_APPEND,   32'd5, '0);
        send_request(OP_READ,     '0, 7'd1);
        send_request(OP_READ,     '0, 7'd5);
        send_request(OP_READ,     '0, 7'd0);
        send_request(OP_READ,     '0, 7'd6);
        send_request(OP_READ,     '0, 7'd127);
        send_request(OP_CONTAINS, 32'h7fff_ffff, '0);
        send_request(OP_CONTAINS, 32'd12345, '0);
        send_request(OP_DELETE,   '0, 7'd1);
        send_request(OP_DELETE,   '0, 7'd2);
        send_request(OP_DELETE,   '0, 7'd3);
        send_request(OP_COUNT,    '0, '0);
        send_request(OP_SPARE_LO, '1, 7'd1);
        send_request(OP_SPARE_HI, '1, 7'd2);
        send_request(OP_CLEAR,    '0, '0);
        send_request(OP_READ,     '0, 7'd1);
        send_request(OP_APPEND,   32'd42, '0);

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 57; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 57; end
                default: begin src_idle_pct = 8; sink_stall_pct = 8; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                op = pick_op(ph % 3);
                val = (op == OP_CONTAINS) ? pick_probe() : pick_value();
                send_request(op, val, pick_position());
            end
        end
        i_in_valid <= 1'b0;
        src_idle_pct = 0;
        sink_stall_pct = 0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("checked %0d results of %0d requests under four flow-control mixes",
                 sb.checked, sb.requests);
        $display("full-list refusals %0d, bad positions %0d, contains hits %0d",
                 sb.full_refusals, sb.range_errors, sb.hits);
        if (sb.errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Regression FAIL");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/olt_pkg.sv
hdl/olt_cell.sv
hdl/ordered_list_table_core.sv
verif/ordered_list_table_core_test.sv
